[hdl/gse_pkg.sv]
// gse_pkg: shared types, constants and reset values of the SIS event stepper.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package gse_pkg;

   localparam int COUNT_BITS     = 24;
   localparam int RANDOM_BITS    = 32;
   localparam int TIME_FRAC_BITS = 32;
   localparam int TIME_BITS      = 63;
   localparam int RATE_BITS      = 16;
   localparam int TIME_SHIFT     = TIME_FRAC_BITS - RATE_BITS;

   localparam int PROD_BITS      = 2 * COUNT_BITS;
   localparam int RPROD_BITS     = RATE_BITS + COUNT_BITS;
   localparam int TOTAL_BITS     = RPROD_BITS + 2;
   localparam int LOG_INT_BITS   = 6;
   localparam int ELOG_BITS      = LOG_INT_BITS + RANDOM_BITS;
   localparam int DVD_BITS       = ELOG_BITS + TIME_SHIFT;
   localparam int STEP_BITS      = 6;
   localparam int SHIFT_BITS     = 5;
   localparam int TOTAL_LO_BITS  = 21;
   localparam int TOTAL_HI_BITS  = TOTAL_BITS - TOTAL_LO_BITS;
   localparam int PPROD_BITS     = RANDOM_BITS + TOTAL_LO_BITS;
   localparam int CMP_BITS       = TOTAL_BITS + RANDOM_BITS;

   localparam logic [RANDOM_BITS-1:0] LN2_Q32  = 32'd2977044472;
   localparam logic [TIME_BITS-1:0]   TIME_MAX = {TIME_BITS{1'b1}};

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 63;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POPULATION       = 3'd0,
      CSR_INITIAL_INFECTED = 3'd1,
      CSR_INFECT_RATE      = 3'd2,
      CSR_RECOVER_RATE     = 3'd3,
      CSR_TIME_LIMIT       = 3'd4
   } csr_index_type;

   localparam logic [COUNT_BITS-1:0] RST_POPULATION       = 24'd5000000;
   localparam logic [COUNT_BITS-1:0] RST_INITIAL_INFECTED = 24'd50;
   localparam logic [RATE_BITS-1:0]  RST_INFECT_RATE      = 16'd13107;
   localparam logic [RATE_BITS-1:0]  RST_RECOVER_RATE     = 16'd9830;
   localparam logic [TIME_BITS-1:0]  RST_TIME_LIMIT       = 63'd3006477107200;

   typedef enum logic [1:0] {
      KIND_INFECT  = 2'd0,
      KIND_RECOVER = 2'd1,
      KIND_NONE    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      DIV_SEL_PAIRS    = 2'd0,
      DIV_SEL_FRACTION = 2'd1,
      DIV_SEL_WAIT     = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic [RANDOM_BITS-1:0] uniform_time;
      logic [RANDOM_BITS-1:0] uniform_pick;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] infected_count;
      logic [COUNT_BITS-1:0] susceptible_count;
      logic [TIME_BITS-1:0]  sim_time;
      kind_type              event_kind;
      logic                  finished;
   } rsp_type;

   typedef struct packed {
      logic        capture;
      logic        div_start;
      div_sel_type div_sel;
      logic        rates_prod;
      logic        rates_sum;
      logic        mult;
      logic        cmp;
      logic        norm_step;
      logic        sqr_step;
      logic        ln_a;
      logic        ln_b;
      logic        update;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic run;
      logic total_zero;
      logic norm_done;
      logic div_busy;
   } status_type;

endpackage

[hdl/gillespie_sis_event_step.sv]
// gillespie_sis_event_step: top level of the SIS Gillespie event stepper.
// Depends on gse_pkg, gse_ctrl, gse_datapath (and gse_div below it).
//
//   channel | direction | handshake         | payload
//   req_    | in        | req_valid/stall   | gse_pkg::req_type
//   rsp_    | out       | rsp_valid/stall   | gse_pkg::rsp_type
//   csr_    | in        | csr_valid/ready   | csr_index, csr_wdata
//
// An item that applies an event runs rate divisions of 48 and 40 steps and the wait-time
// division of 54 steps in a shared one-bit-per-cycle divider, 0 to 31 normalize shifts
// and 32 squaring rounds. Zero total rate skips the pick, the log and the wait-time
// division; an item that fails the run check goes from setup straight to its result.
// Reset is synchronous and loads the default configuration; any csr write to a
// listed register reloads state. A stalled result holds the next one in its last step.
module gillespie_sis_event_step (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  gse_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output gse_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gse_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gse_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   gse_pkg::cmd_type    cmd;
   gse_pkg::status_type status;

   assign csr_ready = 1'b1;

   gse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gse_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   a_div_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider not busy after start");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a step is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("stalled result overwritten");
`endif

endmodule

[hdl/gse_div.sv]
// gse_div: restoring divider, one quotient bit per cycle, dividend left aligned.
// Depends on gse_pkg for widths.
module gse_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [gse_pkg::DVD_BITS-1:0]   dividend,
   input  logic [gse_pkg::TOTAL_BITS-1:0] divisor,
   input  logic [gse_pkg::STEP_BITS-1:0]  steps,
   output logic                           busy,
   output logic [gse_pkg::DVD_BITS-1:0]   quotient,
   output logic [gse_pkg::TOTAL_BITS-1:0] remainder
);

   logic [gse_pkg::STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic [gse_pkg::DVD_BITS-1:0]   dvd_ff, dvd_in;
   logic [gse_pkg::TOTAL_BITS-1:0] rem_ff, rem_in;
   logic [gse_pkg::TOTAL_BITS-1:0] den_ff, den_in;
   logic [gse_pkg::TOTAL_BITS:0]   rem_sh, rem_sub;
   logic                           fits;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[gse_pkg::DVD_BITS-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         cnt_in = steps;
         dvd_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = {dvd_ff[gse_pkg::DVD_BITS-2:0], fits};
         rem_in = rem_sub[gse_pkg::TOTAL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

[hdl/gse_datapath.sv]
// gse_datapath: config registers, epidemic state, rate, log and time arithmetic.
// Depends on gse_pkg and gse_div; sequenced by gse_ctrl through cmd_type.
module gse_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  gse_pkg::req_type                   req_data,
   input  logic                               csr_we,
   input  logic [gse_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gse_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  gse_pkg::cmd_type                   cmd,
   output gse_pkg::status_type                status,
   output gse_pkg::rsp_type                   rsp_data
);

   localparam int CB = gse_pkg::COUNT_BITS;
   localparam int RB = gse_pkg::RANDOM_BITS;
   localparam int TB = gse_pkg::TIME_BITS;
   localparam int QB = gse_pkg::RATE_BITS;
   localparam int XB = gse_pkg::TOTAL_BITS;
   localparam int DB = gse_pkg::DVD_BITS;
   localparam int EB = gse_pkg::ELOG_BITS;
   localparam int LB = gse_pkg::LOG_INT_BITS;
   localparam int SB = gse_pkg::SHIFT_BITS;
   localparam int PB = gse_pkg::PPROD_BITS;
   localparam int CMPB = gse_pkg::CMP_BITS;
   localparam int LO = gse_pkg::TOTAL_LO_BITS;

   logic [CB-1:0] pop_ff, pop_in, init_ff, init_in;
   logic [QB-1:0] brate_ff, brate_in, grate_ff, grate_in;
   logic [TB-1:0] lim_ff, lim_in;
   logic          reload;
   logic [CB-1:0] inf_load;

   logic [CB-1:0] inf_ff, inf_in, sus_ff, sus_in;
   logic [TB-1:0] ela_ff, ela_in;
   gse_pkg::kind_type kind_ff, kind_in;

   logic [RB-1:0] u2_ff, m_ff, m_in, frac_ff, frac_in;
   logic [SB-1:0] sh_ff, sh_in;
   logic [CB-1:0] n_ff;
   logic [gse_pkg::PROD_BITS-1:0]  si_ff;
   logic [gse_pkg::RPROD_BITS-1:0] bq_ff, br_ff, gi_ff;
   logic [XB-1:0] r1_ff, r1_in, total_ff;
   logic [PB-1:0] plo_ff, phi_ff;
   logic          infect_ff;
   logic [2*RB-1:0] lnp_ff, sq;
   logic [LB-1:0] nh_ff;
   logic [EB-1:0] e_ff;
   logic [RB:0]   sq_top;
   logic [LB+RB-1:0] nl;
   logic [CMPB-1:0]  prod, bound;
   logic [TB:0]      sum;
   gse_pkg::rsp_type rsp_ff;

   logic              div_busy;
   logic [DB-1:0]     div_dvd, div_quo;
   logic [XB-1:0]     div_den, div_rem;
   logic [gse_pkg::STEP_BITS-1:0] div_steps;

   always_comb begin
      pop_in   = pop_ff;
      init_in  = init_ff;
      brate_in = brate_ff;
      grate_in = grate_ff;
      lim_in   = lim_ff;
      reload   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            gse_pkg::CSR_POPULATION: begin
               pop_in = csr_wdata[CB-1:0];
               reload = 1'b1;
            end
            gse_pkg::CSR_INITIAL_INFECTED: begin
               init_in = csr_wdata[CB-1:0];
               reload  = 1'b1;
            end
            gse_pkg::CSR_INFECT_RATE: begin
               brate_in = csr_wdata[QB-1:0];
               reload   = 1'b1;
            end
            gse_pkg::CSR_RECOVER_RATE: begin
               grate_in = csr_wdata[QB-1:0];
               reload   = 1'b1;
            end
            gse_pkg::CSR_TIME_LIMIT: begin
               lim_in = csr_wdata[TB-1:0];
               reload = 1'b1;
            end
            default: begin
            end
         endcase
      end
      inf_load = (init_in > pop_in) ? pop_in : init_in;
   end

   always_comb begin
      sq     = m_ff * m_ff;
      sq_top = sq[2*RB-1:RB-1];
      nl     = {LB'({1'b0, sh_ff} + 6'd1), {RB{1'b0}}} - {{LB{1'b0}}, frac_ff};
      prod   = {phi_ff, {LO{1'b0}}} + {{LO{1'b0}}, plo_ff};
      bound  = {r1_ff, {RB{1'b0}}};
      r1_in  = {2'b00, bq_ff} + {{(XB-QB){1'b0}}, div_quo[QB-1:0]};
      sum    = {1'b0, ela_ff} + {{(TB+1-DB){1'b0}}, div_quo};

      m_in    = m_ff;
      sh_in   = sh_ff;
      frac_in = frac_ff;
      if (cmd.capture) begin
         m_in  = (req_data.uniform_time == '0) ? RB'(1) : req_data.uniform_time;
         sh_in = '0;
      end else if (cmd.norm_step) begin
         m_in  = {m_ff[RB-2:0], 1'b0};
         sh_in = sh_ff + 1'b1;
      end else if (cmd.sqr_step) begin
         m_in    = sq_top[RB] ? sq_top[RB:1] : sq_top[RB-1:0];
         frac_in = {frac_ff[RB-2:0], sq_top[RB]};
      end

      inf_in  = inf_ff;
      sus_in  = sus_ff;
      ela_in  = ela_ff;
      kind_in = kind_ff;
      if (reload) begin
         inf_in = inf_load;
         sus_in = pop_in - inf_load;
         ela_in = '0;
      end else if (cmd.capture) begin
         kind_in = gse_pkg::KIND_NONE;
      end else if (cmd.update) begin
         if (total_ff == '0) begin
            ela_in = gse_pkg::TIME_MAX;
         end else begin
            ela_in = sum[TB] ? gse_pkg::TIME_MAX : sum[TB-1:0];
            if (infect_ff) begin
               inf_in  = inf_ff + 1'b1;
               sus_in  = sus_ff - 1'b1;
               kind_in = gse_pkg::KIND_INFECT;
            end else begin
               inf_in  = inf_ff - 1'b1;
               sus_in  = sus_ff + 1'b1;
               kind_in = gse_pkg::KIND_RECOVER;
            end
         end
      end
   end

   always_comb begin
      case (cmd.div_sel)
         gse_pkg::DIV_SEL_PAIRS: begin
            div_dvd   = {si_ff, {(DB-gse_pkg::PROD_BITS){1'b0}}};
            div_den   = {{(XB-CB){1'b0}}, n_ff};
            div_steps = gse_pkg::STEP_BITS'(gse_pkg::PROD_BITS);
         end
         gse_pkg::DIV_SEL_FRACTION: begin
            div_dvd   = {br_ff, {(DB-gse_pkg::RPROD_BITS){1'b0}}};
            div_den   = {{(XB-CB){1'b0}}, n_ff};
            div_steps = gse_pkg::STEP_BITS'(gse_pkg::RPROD_BITS);
         end
         gse_pkg::DIV_SEL_WAIT: begin
            div_dvd   = {e_ff, {gse_pkg::TIME_SHIFT{1'b0}}};
            div_den   = total_ff;
            div_steps = gse_pkg::STEP_BITS'(DB);
         end
         default: begin
            div_dvd   = '0;
            div_den   = '0;
            div_steps = '0;
         end
      endcase
   end

   gse_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (div_den),
      .steps     (div_steps),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_ff   <= gse_pkg::RST_POPULATION;
         init_ff  <= gse_pkg::RST_INITIAL_INFECTED;
         brate_ff <= gse_pkg::RST_INFECT_RATE;
         grate_ff <= gse_pkg::RST_RECOVER_RATE;
         lim_ff   <= gse_pkg::RST_TIME_LIMIT;
         inf_ff   <= gse_pkg::RST_INITIAL_INFECTED;
         sus_ff   <= gse_pkg::RST_POPULATION - gse_pkg::RST_INITIAL_INFECTED;
         ela_ff   <= '0;
         kind_ff  <= gse_pkg::KIND_NONE;
      end else begin
         pop_ff   <= pop_in;
         init_ff  <= init_in;
         brate_ff <= brate_in;
         grate_ff <= grate_in;
         lim_ff   <= lim_in;
         inf_ff   <= inf_in;
         sus_ff   <= sus_in;
         ela_ff   <= ela_in;
         kind_ff  <= kind_in;
      end
      m_ff    <= m_in;
      sh_ff   <= sh_in;
      frac_ff <= frac_in;
      if (cmd.capture) begin
         u2_ff <= req_data.uniform_pick;
         n_ff  <= sus_ff + inf_ff;
         si_ff <= sus_ff * inf_ff;
      end
      if (cmd.rates_prod) begin
         bq_ff <= brate_ff * div_quo[CB-1:0];
         br_ff <= brate_ff * div_rem[CB-1:0];
         gi_ff <= grate_ff * inf_ff;
      end
      if (cmd.rates_sum) begin
         r1_ff    <= r1_in;
         total_ff <= r1_in + {2'b00, gi_ff};
      end
      if (cmd.mult) begin
         plo_ff <= u2_ff * total_ff[LO-1:0];
         phi_ff <= u2_ff * total_ff[XB-1:LO];
      end
      if (cmd.cmp) begin
         infect_ff <= (r1_ff != '0) && (prod <= bound);
      end
      if (cmd.ln_a) begin
         lnp_ff <= nl[RB-1:0] * gse_pkg::LN2_Q32;
         nh_ff  <= nl[LB+RB-1:RB];
      end
      if (cmd.ln_b) begin
         e_ff <= (EB'(nh_ff) * EB'(gse_pkg::LN2_Q32)) + {{LB{1'b0}}, lnp_ff[2*RB-1:RB]};
      end
      if (cmd.out_load) begin
         rsp_ff.infected_count    <= inf_ff;
         rsp_ff.susceptible_count <= sus_ff;
         rsp_ff.sim_time          <= ela_ff;
         rsp_ff.event_kind        <= kind_ff;
         rsp_ff.finished          <= (ela_ff >= lim_ff) || (inf_ff == '0);
      end
   end

   assign status.run        = (ela_ff < lim_ff) && (inf_ff != '0);
   assign status.total_zero = total_ff == '0;
   assign status.norm_done  = m_ff[RB-1];
   assign status.div_busy   = div_busy;
   assign rsp_data          = rsp_ff;

endmodule

[hdl/gse_ctrl.sv]
// gse_ctrl: one-hot sequencer for one event step and the result handshake.
// Depends on gse_pkg; drives gse_datapath via cmd_type, reads status_type.
module gse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  gse_pkg::status_type status,
   output gse_pkg::cmd_type    cmd
);

   typedef enum logic [17:0] {
      ST_IDLE       = 18'h00001,
      ST_SETUP      = 18'h00002,
      ST_DIV1       = 18'h00004,
      ST_R1A        = 18'h00008,
      ST_DIV2_START = 18'h00010,
      ST_DIV2       = 18'h00020,
      ST_R1B        = 18'h00040,
      ST_CHK        = 18'h00080,
      ST_MULT       = 18'h00100,
      ST_CMP        = 18'h00200,
      ST_NORM       = 18'h00400,
      ST_SQR        = 18'h00800,
      ST_LNA        = 18'h01000,
      ST_LNB        = 18'h02000,
      ST_DIV3_START = 18'h04000,
      ST_DIV3       = 18'h08000,
      ST_UPD        = 18'h10000,
      ST_FIN        = 18'h20000
   } state_type;

   state_type state_ff, state_in;
   logic [gse_pkg::SHIFT_BITS-1:0] rnd_ff, rnd_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      rnd_in      = rnd_ff;
      cmd         = '0;
      cmd.div_sel = gse_pkg::DIV_SEL_PAIRS;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (status.run) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV1: begin
            if (!status.div_busy) state_in = ST_R1A;
         end
         ST_R1A: begin
            cmd.rates_prod = 1'b1;
            state_in       = ST_DIV2_START;
         end
         ST_DIV2_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = gse_pkg::DIV_SEL_FRACTION;
            state_in      = ST_DIV2;
         end
         ST_DIV2: begin
            if (!status.div_busy) state_in = ST_R1B;
         end
         ST_R1B: begin
            cmd.rates_sum = 1'b1;
            state_in      = ST_CHK;
         end
         ST_CHK: begin
            state_in = status.total_zero ? ST_UPD : ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.norm_done) begin
               state_in = ST_SQR;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_SQR: begin
            cmd.sqr_step = 1'b1;
            rnd_in       = rnd_ff + 1'b1;
            if (rnd_ff == {gse_pkg::SHIFT_BITS{1'b1}}) state_in = ST_LNA;
         end
         ST_LNA: begin
            cmd.ln_a = 1'b1;
            state_in = ST_LNB;
         end
         ST_LNB: begin
            cmd.ln_b = 1'b1;
            state_in = ST_DIV3_START;
         end
         ST_DIV3_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = gse_pkg::DIV_SEL_WAIT;
            state_in      = ST_DIV3;
         end
         ST_DIV3: begin
            if (!status.div_busy) state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

[dv/gse_checker.sv]
// gse_checker: watches the csr, req_ and rsp_ channels of the SIS event stepper,
// predicts every result and compares it field by field. Depends on gse_pkg.
module gse_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  gse_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  gse_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [gse_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gse_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 fail_count,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] TMAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

   logic [63:0] population, initial_infected, infect_rate, recover_rate, time_limit;
   logic [63:0] infected, susceptible, elapsed;
   gse_pkg::rsp_type expected_q[$];

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
      fail_count++;
   endtask

   task automatic reload();
      logic [63:0] n, i;
      n = population;
      i = initial_infected;
      if (i > n) i = n;
      infected = i;
      susceptible = n - i;
      elapsed = 0;
   endtask

   function automatic logic [63:0] neg_log(input logic [63:0] u_in);
      logic [63:0] u, m, frac, nl;
      int k;
      u = u_in & 64'hFFFF_FFFF;
      if (u == 0) u = 1;
      k = 0;
      while (k < 31 && (u >> (k + 1)) != 0) k++;
      m = u << (31 - k);
      frac = 0;
      for (int r = 0; r < 32; r++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      nl = (64'(32 - k) << 32) - frac;
      return (nl >> 32) * 64'(gse_pkg::LN2_Q32)
             + (((nl & 64'hFFFF_FFFF) * 64'(gse_pkg::LN2_Q32)) >> 32);
   endfunction

   function automatic gse_pkg::rsp_type advance(input gse_pkg::req_type item);
      gse_pkg::rsp_type  r;
      gse_pkg::kind_type kind;
      logic [63:0]  n, si, r1, total, dt, sum;
      logic [127:0] lhs, rhs;
      kind = gse_pkg::KIND_NONE;
      if (elapsed < time_limit && infected > 0) begin
         n = susceptible + infected;
         si = susceptible * infected;
         r1 = infect_rate * (si / n) + (infect_rate * (si % n)) / n;
         total = r1 + recover_rate * infected;
         if (total == 0) begin
            elapsed = TMAX64;
         end else begin
            lhs = 128'(item.uniform_pick) * 128'(total);
            rhs = 128'(r1) << 32;
            if (r1 > 0 && lhs <= rhs) begin
               susceptible--;
               infected++;
               kind = gse_pkg::KIND_INFECT;
            end else begin
               infected--;
               susceptible++;
               kind = gse_pkg::KIND_RECOVER;
            end
            dt = (neg_log(64'(item.uniform_time)) << gse_pkg::TIME_SHIFT) / total;
            sum = elapsed + dt;
            elapsed = (sum > TMAX64) ? TMAX64 : sum;
         end
      end
      r.infected_count = infected[gse_pkg::COUNT_BITS-1:0];
      r.susceptible_count = susceptible[gse_pkg::COUNT_BITS-1:0];
      r.sim_time = elapsed[gse_pkg::TIME_BITS-1:0];
      r.event_kind = kind;
      r.finished = (elapsed >= time_limit || infected == 0);
      return r;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      gse_pkg::rsp_type exp;
      if (reset) begin
         population = 64'(gse_pkg::RST_POPULATION);
         initial_infected = 64'(gse_pkg::RST_INITIAL_INFECTED);
         infect_rate = 64'(gse_pkg::RST_INFECT_RATE);
         recover_rate = 64'(gse_pkg::RST_RECOVER_RATE);
         time_limit = 64'(gse_pkg::RST_TIME_LIMIT);
         reload();
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report("unexpected transaction", 0, 0);
            end else begin
               exp = expected_q.pop_front();
               if (rsp_data.infected_count !== exp.infected_count)
                  report("infected_count", rsp_data.infected_count, exp.infected_count);
               if (rsp_data.susceptible_count !== exp.susceptible_count)
                  report("susceptible_count", rsp_data.susceptible_count,
                         exp.susceptible_count);
               if (rsp_data.sim_time !== exp.sim_time)
                  report("sim_time", rsp_data.sim_time, exp.sim_time);
               if (rsp_data.event_kind !== exp.event_kind)
                  report("event_kind", rsp_data.event_kind, exp.event_kind);
               if (rsp_data.finished !== exp.finished)
                  report("finished", rsp_data.finished, exp.finished);
            end
         end
         if (req_valid && !req_stall)
            expected_q.insert(expected_q.size(), advance(req_data));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gse_pkg::CSR_POPULATION:
                  population = 64'(csr_wdata[gse_pkg::COUNT_BITS-1:0]);
               gse_pkg::CSR_INITIAL_INFECTED:
                  initial_infected = 64'(csr_wdata[gse_pkg::COUNT_BITS-1:0]);
               gse_pkg::CSR_INFECT_RATE:
                  infect_rate = 64'(csr_wdata[gse_pkg::RATE_BITS-1:0]);
               gse_pkg::CSR_RECOVER_RATE:
                  recover_rate = 64'(csr_wdata[gse_pkg::RATE_BITS-1:0]);
               gse_pkg::CSR_TIME_LIMIT:
                  time_limit = 64'(csr_wdata[gse_pkg::TIME_BITS-1:0]);
               default: ;
            endcase
            if (csr_index <= gse_pkg::CSR_TIME_LIMIT) reload();
         end
      end
   end

   initial fail_count = 0;
endmodule

[dv/tb_top.sv]
// tb_top: stimulus and verdict for gillespie_sis_event_step.
// Depends on gse_pkg, the RTL and dv/gse_checker.sv, which checks every result.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic                               clock = 0;
   logic                               reset = 1;
   logic                               req_valid = 0;
   logic                               req_stall;
   gse_pkg::req_type                   req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 0;
   gse_pkg::rsp_type                   rsp_data;
   logic                               csr_valid = 0;
   logic                               csr_ready;
   logic [gse_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [gse_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;
   int                                 fail_count, pending;
   int                                 sent = 0, received = 0, cycles = 0;
   int                                 idle_pct = 0, stall_pct = 0;
   logic                               last_finished = 0;

   gillespie_sis_event_step u_dut (.*);

   gse_checker u_checker (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("FAIL");
         $finish;
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         received <= received + 1;
         last_finished <= rsp_data.finished;
      end
   end

   task automatic send(input logic [31:0] u1, input logic [31:0] u2);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{uniform_time: u1, uniform_pick: u2};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic settle();
      req_valid <= 0;
      while (received != sent) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [gse_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [62:0] val);
      settle();
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic setup(input logic [23:0] pop, input logic [23:0] inf, input logic [15:0] b,
                        input logic [15:0] g, input logic [62:0] lim);
      write_reg(gse_pkg::CSR_POPULATION, 63'(pop));
      write_reg(gse_pkg::CSR_INFECT_RATE, 63'(b));
      write_reg(gse_pkg::CSR_RECOVER_RATE, 63'(g));
      write_reg(gse_pkg::CSR_TIME_LIMIT, lim);
      write_reg(gse_pkg::CSR_INITIAL_INFECTED, 63'(inf));
   endtask

   function automatic logic [62:0] rand_limit();
      case ($urandom_range(5))
         0: return 63'({$urandom(), $urandom()});
         1: return {31'd0, $urandom()};
         default: return {27'd0, 4'($urandom_range(15)), $urandom()};
      endcase
   endfunction

   initial begin
      logic [23:0] pop;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // extremes of the random fractions, default setting
      send(32'd0, 32'd0);
      send(32'd1, 32'hFFFF_FFFF);
      send(32'hFFFF_FFFF, 32'd0);
      send(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(32'h8000_0000, 32'h8000_0000);
      // out-of-range register index: ignored
      write_reg(3'd5, 63'd1);
      send(32'h1234_5678, 32'h0);
      // zero total rate
      setup(24'd4, 24'd2, 16'd0, 16'd0, 63'd1 << 40);
      send(32'hAAAA_AAAA, 32'h5555_5555);
      send(32'h5555_5555, 32'hAAAA_AAAA);
      // zero infection rate with zero pick
      setup(24'd8, 24'd3, 16'd0, 16'hFFFF, {63{1'b1}});
      send(32'd7, 32'd0);
      send(32'd0, 32'd0);
      // zero population, clamp, zero limit, full-scale values
      setup(24'd0, 24'd5, 16'hFFFF, 16'hFFFF, {63{1'b1}});
      send(32'h1, 32'h1);
      setup(24'd3, 24'hFF_FFFF, 16'hFFFF, 16'h1, {63{1'b1}});
      send(32'h9, 32'h0);
      send(32'h9, 32'hFFFF_FFFF);
      setup(24'hFF_FFFF, 24'h7F_FFFF, 16'hFFFF, 16'hFFFF, 63'd0);
      send(32'h4000_0000, 32'h1);
      setup(24'hFF_FFFF, 24'h1, 16'hFFFF, 16'h0, {63{1'b1}});
      send(32'h1, 32'h0);
      send(32'h2, 32'h0);
      setup(24'd1, 24'd1, 16'hFFFF, 16'hFFFF, 63'd1);
      send(32'hFFFF_FFFF, 32'h0);

      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 67; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 67; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         if (phase == 0) begin
            write_reg(gse_pkg::CSR_POPULATION, 63'(gse_pkg::RST_POPULATION));
            write_reg(gse_pkg::CSR_INITIAL_INFECTED, 63'(gse_pkg::RST_INITIAL_INFECTED));
            write_reg(gse_pkg::CSR_INFECT_RATE, 63'(gse_pkg::RST_INFECT_RATE));
            write_reg(gse_pkg::CSR_RECOVER_RATE, 63'(gse_pkg::RST_RECOVER_RATE));
            write_reg(gse_pkg::CSR_TIME_LIMIT, 63'(gse_pkg::RST_TIME_LIMIT));
         end else begin
            pop = ($urandom_range(4) == 0) ? 24'($urandom()) : 24'($urandom_range(1, 60));
            setup(pop, 24'($urandom_range(0, 32'(pop))), 16'($urandom()), 16'($urandom()),
                  rand_limit());
         end
         for (int chunk = 0; chunk < 5; chunk++) begin
            for (int n = 0; n < 15; n++) send($urandom(), $urandom());
            settle();
            if (last_finished) begin
               if ($urandom_range(3) == 0)
                  write_reg(gse_pkg::CSR_TIME_LIMIT, rand_limit());
               write_reg(gse_pkg::CSR_INITIAL_INFECTED, 63'($urandom_range(1, 40)));
            end
         end
      end

      idle_pct = 0;
      settle();
      repeat (250) @(posedge clock);
      if (fail_count == 0 && pending == 0 && received == sent) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

[files.f]
hdl/gse_pkg.sv
hdl/gse_div.sv
hdl/gse_datapath.sv
hdl/gse_ctrl.sv
hdl/gillespie_sis_event_step.sv
dv/gse_checker.sv
dv/tb_top.sv
